@@ sv/nfpb_pkg.sv @@
`timescale 1ns / 1ps

package nfpb_pkg;

   // Default geometry of the array
   localparam int BLOCK_COUNT_DEF = 256;
   localparam int BLOCK_PAGES_DEF = 64;
   localparam int DATA_WIDTH_DEF  = 64;

   // Field widths fixed by the interface
   localparam int MAP_W   = 64;   // widest written-page bitmap
   localparam int CNT_W   = 7;    // valid and free page counts
   localparam int WEAR_W  = 16;
   localparam int LBA_W   = 32;
   localparam int TOT_W   = 32;
   localparam int BIU_W   = 9;
   localparam int CSR_W   = 16;

   // Register reset values
   localparam logic [WEAR_W-1:0] MAX_PE_RESET = 16'd3000;
   localparam logic [BIU_W-1:0]  BLOCKS_RESET = 9'd256;

   // Register indexes
   localparam logic CSR_MAX_PE = 1'b0;
   localparam logic CSR_BLOCKS = 1'b1;

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_ERASE = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_RANGE     = 3'd1,
      STAT_FREE_PAGE = 3'd2,
      STAT_USED_PAGE = 3'd3,
      STAT_WORN      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MODE_FREE   = 2'd0,
      MODE_ACTIVE = 2'd1,
      MODE_FULL   = 2'd2
   } blk_mode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // One entry of the block state memory
   typedef struct packed {
      logic [MAP_W-1:0]  page_map;
      blk_mode_type      mode;
      logic [CNT_W-1:0]  valid_cnt;
      logic [CNT_W-1:0]  free_cnt;
      logic [WEAR_W-1:0] wear;
   } blk_rec_type;

   // Outcome of one request, from the execute logic to the sequencer
   typedef struct packed {
      status_type  status;
      blk_rec_type rec;
      logic        blk_ok;
      logic        blk_we;
      logic        page_we;
      logic        rd_ok;
      logic        wr_ok;
      logic        er_ok;
   } exec_res_type;

endpackage

@@ sv/nand_flash_page_block_model.sv @@
`timescale 1ns / 1ps
// NAND flash page and block bookkeeping.
// Request channel: drive start with req_type (0 read, 1 write, 2 erase), the block and
// page index, the write data and the logical address. A beat is taken at a rising edge
// with start high and busy low.
// Result channel: rsp_valid is high for exactly one cycle with status, read data, the
// sequence number of a write, the addressed block's state and the global counters.
// The receiver cannot stall; a result is taken in the cycle it is shown.
// Timing: the request beat moves the sequencer to its execute state, and the result
// strobe is registered from that state. The accepting edge reads the block and page
// memories, the execute state checks the request and writes both memories back, and
// busy stays high through it, so the next request always reads what this one wrote.
// Reset: busy stays high while a clearing pass writes every block entry back to free,
// empty and unworn. Config writes are taken at any time.
// CSR: csr_index 0 is the wear limit (reset 3000), 1 is blocks_in_use (reset 256).
// Page entries are never cleared; page data is only returned after the page has been written.
module nand_flash_page_block_model
   import nfpb_pkg::*;
#(
   parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
   parameter int BLOCK_PAGES = BLOCK_PAGES_DEF,
   parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_block_index,
   input  logic [5:0]        req_page_index,
   input  logic [63:0]       req_write_data,
   input  logic [LBA_W-1:0]  req_logical_address,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [63:0]       rsp_read_data,
   output logic [LBA_W-1:0]  rsp_read_lba,
   output logic [TOT_W-1:0]  rsp_assigned_seq,
   output logic [1:0]        rsp_block_state,
   output logic [CNT_W-1:0]  rsp_block_valid_pages,
   output logic [CNT_W-1:0]  rsp_block_free_pages,
   output logic [WEAR_W-1:0] rsp_block_erase_count,
   output logic [TOT_W-1:0]  rsp_reads_done,
   output logic [TOT_W-1:0]  rsp_writes_done,
   output logic [TOT_W-1:0]  rsp_erases_done,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam int BLK_W  = $clog2(BLOCK_COUNT);
   localparam int PG_W   = $clog2(BLOCK_PAGES);
   localparam int IDX_W  = (BLK_W > 8) ? BLK_W : 8;
   localparam int PAGE_W = DATA_WIDTH + LBA_W;
   localparam int REC_W  = $bits(blk_rec_type);

   localparam blk_rec_type REC_RESET = '{
      page_map:  '0,
      mode:      MODE_FREE,
      valid_cnt: '0,
      free_cnt:  CNT_W'(BLOCK_PAGES),
      wear:      '0
   };

   state_type             state_ff, state_in;
   logic [BLK_W-1:0]      clr_ff;
   logic                  accept;

   logic [1:0]            type_ff;
   logic [7:0]            blk_ff;
   logic [5:0]            pg_ff;
   logic [DATA_WIDTH-1:0] wdata_ff;
   logic [LBA_W-1:0]      lba_ff;

   logic [WEAR_W-1:0]     max_pe_ff;
   logic [BIU_W-1:0]      biu_ff;

   logic [TOT_W-1:0]      seq_ff;
   logic [TOT_W-1:0]      rd_total_ff;
   logic [TOT_W-1:0]      wr_total_ff;
   logic [TOT_W-1:0]      er_total_ff;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [63:0]           rsp_data_ff;
   logic [LBA_W-1:0]      rsp_lba_ff;
   logic [TOT_W-1:0]      rsp_seq_ff;
   blk_rec_type           rsp_rec_ff;

   logic [IDX_W-1:0]      req_blk_ext;
   logic [IDX_W-1:0]      cur_blk_ext;
   logic [BLK_W-1:0]      cur_blk_addr;

   logic                  blk_we;
   logic [BLK_W-1:0]      blk_waddr;
   blk_rec_type           blk_wrec;
   logic [REC_W-1:0]      blk_rdata;
   blk_rec_type           blk_rrec;
   logic [PAGE_W-1:0]     page_rdata;
   logic [TOT_W-1:0]      seq_next;
   exec_res_type          ex;

   assign req_blk_ext  = IDX_W'(req_block_index);
   assign cur_blk_ext  = IDX_W'(blk_ff);
   assign cur_blk_addr = cur_blk_ext[BLK_W-1:0];
   assign blk_rrec     = blk_rec_type'(blk_rdata);
   assign seq_next     = seq_ff + TOT_W'(1);

   // Sequencer: clearing pass, idle, execute
   always_comb begin
      state_in = state_ff;
      busy     = 1'b1;
      accept   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == BLK_W'(BLOCK_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy   = 1'b0;
            accept = start;
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + BLK_W'(1);
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_pe_ff <= MAX_PE_RESET;
         biu_ff    <= BLOCKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_PE: max_pe_ff <= csr_wdata;
            CSR_BLOCKS: biu_ff    <= csr_wdata[BIU_W-1:0];
            default: ;
         endcase
      end
   end

   // Hold the request beat for the execute cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_type;
         blk_ff   <= req_block_index;
         pg_ff    <= req_page_index;
         wdata_ff <= req_write_data[DATA_WIDTH-1:0];
         lba_ff   <= req_logical_address;
      end
   end

   // Block memory write port: clearing pass or write-back
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         blk_we    = 1'b1;
         blk_waddr = clr_ff;
         blk_wrec  = REC_RESET;
      end else begin
         blk_we    = (state_ff == ST_EXEC) && ex.blk_we;
         blk_waddr = cur_blk_addr;
         blk_wrec  = ex.rec;
      end
   end

   nfpb_ram #(
      .WIDTH (REC_W),
      .DEPTH (BLOCK_COUNT),
      .AW    (BLK_W)
   ) u_blk_ram (
      .clock (clock),
      .we    (blk_we),
      .waddr (blk_waddr),
      .wdata (blk_wrec),
      .re    (accept),
      .raddr (req_blk_ext[BLK_W-1:0]),
      .rdata (blk_rdata)
   );

   nfpb_ram #(
      .WIDTH (PAGE_W),
      .DEPTH (BLOCK_COUNT << PG_W),
      .AW    (BLK_W + PG_W)
   ) u_page_ram (
      .clock (clock),
      .we    ((state_ff == ST_EXEC) && ex.page_we),
      .waddr ({cur_blk_addr, pg_ff[PG_W-1:0]}),
      .wdata ({lba_ff, wdata_ff}),
      .re    (accept),
      .raddr ({req_blk_ext[BLK_W-1:0], req_page_index[PG_W-1:0]}),
      .rdata (page_rdata)
   );

   nfpb_exec #(
      .BLOCK_COUNT (BLOCK_COUNT),
      .BLOCK_PAGES (BLOCK_PAGES)
   ) u_exec (
      .rtype         (type_ff),
      .blk           (blk_ff),
      .pg            (pg_ff),
      .rec           (blk_rrec),
      .max_pe        (max_pe_ff),
      .blocks_in_use (biu_ff),
      .res           (ex)
   );

   // Advance the sequence number and the global counters
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= '0;
         rd_total_ff <= '0;
         wr_total_ff <= '0;
         er_total_ff <= '0;
      end else if (state_ff == ST_EXEC) begin
         if (ex.rd_ok) begin
            rd_total_ff <= rd_total_ff + TOT_W'(1);
         end
         if (ex.wr_ok) begin
            seq_ff      <= seq_next;
            wr_total_ff <= wr_total_ff + TOT_W'(1);
         end
         if (ex.er_ok) begin
            er_total_ff <= er_total_ff + TOT_W'(1);
         end
      end
   end

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_EXEC);
      end
   end

   // Result beat payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         rsp_status_ff <= ex.status;
         rsp_data_ff   <= ex.rd_ok ? 64'(page_rdata[DATA_WIDTH-1:0]) : '0;
         rsp_lba_ff    <= ex.rd_ok ? page_rdata[DATA_WIDTH +: LBA_W] : '0;
         rsp_seq_ff    <= ex.wr_ok ? seq_next : '0;
         rsp_rec_ff    <= ex.blk_ok ? ex.rec : '0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_read_data         = rsp_data_ff;
   assign rsp_read_lba          = rsp_lba_ff;
   assign rsp_assigned_seq      = rsp_seq_ff;
   assign rsp_block_state       = rsp_rec_ff.mode;
   assign rsp_block_valid_pages = rsp_rec_ff.valid_cnt;
   assign rsp_block_free_pages  = rsp_rec_ff.free_cnt;
   assign rsp_block_erase_count = rsp_rec_ff.wear;
   assign rsp_reads_done        = rd_total_ff;
   assign rsp_writes_done       = wr_total_ff;
   assign rsp_erases_done       = er_total_ff;

   // Every result beat follows an execute cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EXEC))
      else $error("result beat without an execute cycle");

   // An accepted request is executed in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_EXEC))
      else $error("accepted request not executed");

   // A failed request returns no read data and no sequence number
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> (rsp_read_data == '0 && rsp_assigned_seq == '0))
      else $error("failed request returned payload");

   // In a successful result, the valid and free page counts of the block add up to the block size
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_OK) |->
         (rsp_block_valid_pages + rsp_block_free_pages == CNT_W'(BLOCK_PAGES)))
      else $error("block page counts out of balance");

endmodule

@@ sv/nfpb_ram.sv @@
`timescale 1ns / 1ps

module nfpb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read, held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/nfpb_exec.sv @@
`timescale 1ns / 1ps

module nfpb_exec
   import nfpb_pkg::*;
#(
   parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
   parameter int BLOCK_PAGES = BLOCK_PAGES_DEF
) (
   input  logic [1:0]        rtype,
   input  logic [7:0]        blk,
   input  logic [5:0]        pg,
   input  blk_rec_type       rec,
   input  logic [WEAR_W-1:0] max_pe,
   input  logic [BIU_W-1:0]  blocks_in_use,
   output exec_res_type      res
);

   logic             blk_ok;
   logic             pg_ok;
   logic             worn;
   logic             used;
   logic [CNT_W-1:0] free_dec;

   assign blk_ok   = (BIU_W'(blk) < blocks_in_use) && (13'(blk) < 13'(BLOCK_COUNT));
   assign pg_ok    = 7'(pg) < 7'(BLOCK_PAGES);
   assign worn     = rec.wear >= max_pe;
   assign used     = rec.page_map[pg];
   assign free_dec = (rec.free_cnt != '0) ? rec.free_cnt - CNT_W'(1) : rec.free_cnt;

   // Check the request, then build the updated block entry
   always_comb begin
      res         = '0;
      res.rec     = rec;
      res.status  = STAT_OK;
      res.blk_ok  = blk_ok;
      if (!blk_ok) begin
         res.status = STAT_RANGE;
      end else begin
         case (req_code_type'(rtype))
            REQ_READ: begin
               if (!pg_ok) begin
                  res.status = STAT_RANGE;
               end else if (!used) begin
                  res.status = STAT_FREE_PAGE;
               end else begin
                  res.rd_ok = 1'b1;
               end
            end
            REQ_WRITE: begin
               if (!pg_ok) begin
                  res.status = STAT_RANGE;
               end else if (used) begin
                  res.status = STAT_USED_PAGE;
               end else if (worn) begin
                  res.status = STAT_WORN;
               end else begin
                  res.wr_ok              = 1'b1;
                  res.rec.page_map[pg]   = 1'b1;
                  res.rec.valid_cnt      = rec.valid_cnt + CNT_W'(1);
                  res.rec.free_cnt       = free_dec;
                  if (rec.mode == MODE_FREE) begin
                     res.rec.mode = MODE_ACTIVE;
                  end
                  if (free_dec == '0) begin
                     res.rec.mode = MODE_FULL;
                  end
               end
            end
            REQ_ERASE: begin
               if (worn) begin
                  res.status = STAT_WORN;
               end else begin
                  res.er_ok           = 1'b1;
                  res.rec.page_map    = '0;
                  res.rec.mode        = MODE_FREE;
                  res.rec.valid_cnt   = '0;
                  res.rec.free_cnt    = CNT_W'(BLOCK_PAGES);
                  res.rec.wear        = rec.wear + WEAR_W'(1);
               end
            end
            default: begin
               res.status = STAT_RANGE;
            end
         endcase
      end
      res.blk_we  = res.wr_ok | res.er_ok;
      res.page_we = res.wr_ok;
   end

endmodule
